// ----- hdl/fsp_pkg.sv -----
// Shared types, constants and codes for the frustum sphere/point cull block.
package fsp_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COEF_W          = 32;
  localparam int COEFS_PER_PLANE = 4;
  localparam int ROW_W           = COEF_W * COEFS_PER_PLANE;
  localparam int PROD_W          = 2 * COEF_W;
  localparam int DIST_W          = 66;
  localparam int RAD_W           = 31;
  localparam int FRAC_W          = 16;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SPHERE = 2'd1;
  localparam logic [1:0] FUNC_POINT  = 2'd2;

  localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

  // One plane as stored in a RAM row; nx sits in the low word.
  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] nz;
    logic signed [COEF_W-1:0] ny;
    logic signed [COEF_W-1:0] nx;
  } plane_row_t;

  // Tag that travels beside a plane row through the distance pipeline.
  typedef struct packed {
    logic vld;
    logic last;
  } pipe_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_RUN,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/frustum_sphere_point_cull_core.sv -----
// Frustum cull core: PLANE_COUNT planes live in a RAM, one plane row of four
// Q16.16 words per entry. A load item rewrites one word by reading its row and
// writing it back; a load past the last plane or an unused function code
// writes nothing but still returns a result. A sphere or point test streams
// one plane row per cycle from the RAM through a single shared distance unit
// (three multipliers, then a 66-bit sum): each row passes the RAM read
// register and the two distance stages and is compared into the hit flags,
// and the verdict is registered once the output register is free. The next
// item can be taken in the cycle after the result is registered. One item is
// in work at a time; a result may wait in the output register while the next
// item is accepted, and work on that item pauses at its end until the output
// register is free. Planes must be loaded before any test reads them.
module frustum_sphere_point_cull_core #(
  parameter int PLANE_COUNT = fsp_pkg::PLANE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic [2:0]                          in_plane_sel,
  input  logic [1:0]                          in_coef_sel,
  input  logic signed [fsp_pkg::COEF_W-1:0]   in_coef_value,
  input  logic signed [fsp_pkg::COEF_W-1:0]   in_pos_x,
  input  logic signed [fsp_pkg::COEF_W-1:0]   in_pos_y,
  input  logic signed [fsp_pkg::COEF_W-1:0]   in_pos_z,
  input  logic [fsp_pkg::RAD_W-1:0]           in_sphere_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_verdict
);

  localparam int AW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int DW = fsp_pkg::DIST_W;

  fsp_pkg::state_t state_r, state_nxt;

  logic                              in_acc;
  logic [AW-1:0]                     plane_cnt_r;
  logic [AW-1:0]                     psel_r;
  logic [1:0]                        csel_r;
  logic [fsp_pkg::COEF_W-1:0]        cval_r;
  logic signed [fsp_pkg::COEF_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [fsp_pkg::RAD_W-1:0]         rad_r;
  logic                              far_hit_r, near_hit_r;
  logic                              out_valid_r;
  logic [1:0]                        out_verdict_r;

  logic                                      ram_we, ram_re;
  logic [AW-1:0]                             ram_raddr;
  logic [fsp_pkg::COEFS_PER_PLANE-1:0][fsp_pkg::COEF_W-1:0] ram_rdata, ram_wdata;
  fsp_pkg::pipe_tag_t                        issue_tag, dist_tag;
  fsp_pkg::pipe_tag_t                        issue_tag_d_r;
  logic signed [DW-1:0]                      dist_val;
  logic signed [DW-1:0]                      rad_ext;
  logic                                      out_free;
  logic                                      plane_ok;
  logic [1:0]                                verdict;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != fsp_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign plane_ok = ({1'b0, in_plane_sel} < 4'(PLANE_COUNT));

  // Radius taken to Q32.32; a point test runs as a sphere of radius zero.
  assign rad_ext = $signed({{(DW - fsp_pkg::RAD_W - fsp_pkg::FRAC_W){1'b0}}, rad_r,
                            {fsp_pkg::FRAC_W{1'b0}}});

  always_comb begin
    ram_wdata         = ram_rdata;
    ram_wdata[csel_r] = cval_r;
  end

  always_comb begin
    if (far_hit_r) begin
      verdict = fsp_pkg::VERDICT_OUTSIDE;
    end else if (near_hit_r) begin
      verdict = fsp_pkg::VERDICT_INTERSECT;
    end else begin
      verdict = fsp_pkg::VERDICT_INSIDE;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    ram_raddr      = plane_cnt_r;
    issue_tag      = '0;
    case (state_r)
      fsp_pkg::ST_IDLE: begin
        ram_raddr = in_plane_sel[AW-1:0];
        if (in_acc) begin
          if (in_func == fsp_pkg::FUNC_LOAD && plane_ok) begin
            ram_re    = 1'b1;
            state_nxt = fsp_pkg::ST_LOAD_WR;
          end else if (in_func == fsp_pkg::FUNC_SPHERE || in_func == fsp_pkg::FUNC_POINT) begin
            state_nxt = fsp_pkg::ST_RUN;
          end else begin
            state_nxt = fsp_pkg::ST_DONE;
          end
        end
      end
      fsp_pkg::ST_LOAD_WR: begin
        ram_we    = 1'b1;
        state_nxt = fsp_pkg::ST_DONE;
      end
      fsp_pkg::ST_RUN: begin
        ram_re         = 1'b1;
        issue_tag.vld  = 1'b1;
        issue_tag.last = (plane_cnt_r == AW'(PLANE_COUNT - 1));
        if (issue_tag.last) begin
          state_nxt = fsp_pkg::ST_WAIT;
        end
      end
      fsp_pkg::ST_WAIT: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = fsp_pkg::ST_DONE;
        end
      end
      fsp_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = fsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == fsp_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      psel_r      <= in_plane_sel[AW-1:0];
      csel_r      <= in_coef_sel;
      cval_r      <= in_coef_value;
      pos_x_r     <= in_pos_x;
      pos_y_r     <= in_pos_y;
      pos_z_r     <= in_pos_z;
      rad_r       <= (in_func == fsp_pkg::FUNC_SPHERE) ? in_sphere_radius : '0;
      plane_cnt_r <= '0;
      far_hit_r   <= 1'b0;
      near_hit_r  <= 1'b0;
    end else begin
      if (state_r == fsp_pkg::ST_RUN) begin
        plane_cnt_r <= AW'(plane_cnt_r + 1'b1);
      end
      if (dist_tag.vld) begin
        // dist < -R is checked as dist + R < 0.
        if (dist_val + rad_ext < 0) begin
          far_hit_r <= 1'b1;
        end
        if (dist_val < rad_ext) begin
          near_hit_r <= 1'b1;
        end
      end
    end
    if (state_r == fsp_pkg::ST_DONE && out_free) begin
      out_verdict_r <= verdict;
    end
  end

  fsp_ram #(
    .WIDTH (fsp_pkg::ROW_W),
    .DEPTH (PLANE_COUNT)
  ) u_plane_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (psel_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsp_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (issue_tag_d_r),
    .row      (fsp_pkg::plane_row_t'(ram_rdata)),
    .pos_x    (pos_x_r),
    .pos_y    (pos_y_r),
    .pos_z    (pos_z_r),
    .tag_out  (dist_tag),
    .dist_val (dist_val)
  );

  // The RAM read is registered, so the row arrives in the cycle after its read request; delay the tag to match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_tag_d_r <= '0;
    end else begin
      issue_tag_d_r <= issue_tag;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

// ----- hdl/fsp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/fsp_dist.sv -----
// Two-stage signed distance unit: three products, then the full-precision sum.
module fsp_dist (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fsp_pkg::pipe_tag_t                   tag_in,
  input  fsp_pkg::plane_row_t                  row,
  input  logic signed [fsp_pkg::COEF_W-1:0]    pos_x,
  input  logic signed [fsp_pkg::COEF_W-1:0]    pos_y,
  input  logic signed [fsp_pkg::COEF_W-1:0]    pos_z,
  output fsp_pkg::pipe_tag_t                   tag_out,
  output logic signed [fsp_pkg::DIST_W-1:0]    dist_val
);

  localparam int OFS_W = fsp_pkg::COEF_W + fsp_pkg::FRAC_W;

  fsp_pkg::pipe_tag_t tag1_r, tag2_r;
  logic signed [fsp_pkg::PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [OFS_W-1:0]           ofs_r;
  logic signed [fsp_pkg::DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= row.nx * pos_x;
    py_r   <= row.ny * pos_y;
    pz_r   <= row.nz * pos_z;
    // The offset is Q16.16; scale it to the Q32.32 product format.
    ofs_r  <= $signed({row.d, {fsp_pkg::FRAC_W{1'b0}}});
    dist_r <= fsp_pkg::DIST_W'(px_r) + fsp_pkg::DIST_W'(py_r)
            + fsp_pkg::DIST_W'(pz_r) + fsp_pkg::DIST_W'(ofs_r);
  end

  assign tag_out  = tag2_r;
  assign dist_val = dist_r;

endmodule

// ----- hdl/fsp_check.sv -----
// Port-level checker for the frustum cull core, bound to the top level.
module fsp_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict
);

  // Only one item is in work, so an accepted item always blocks the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted in back-to-back cycles");

  // A load never returns its result in the cycle right after it is taken.
  a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == fsp_pkg::FUNC_LOAD) |=> !$rose(out_valid))
    else $error("load item finished too early");

  // A new result appears only at the end of work on an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == fsp_pkg::VERDICT_INSIDE ||
                   out_verdict == fsp_pkg::VERDICT_INTERSECT ||
                   out_verdict == fsp_pkg::VERDICT_OUTSIDE))
    else $error("verdict outside its code range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_verdict)))
    else $error("stalled result changed");

endmodule

bind frustum_sphere_point_cull_core fsp_check u_fsp_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_func     (in_func),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_verdict (out_verdict)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the frustum sphere and point cull core.
`timescale 1ns / 100ps

module tb;

  localparam int PLANES = fsp_pkg::PLANE_COUNT_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] MIN_WORD = 32'h8000_0000;
  localparam logic [31:0] MAX_WORD = 32'h7fff_ffff;

  typedef struct {
    logic [1:0]         func;
    logic [2:0]         psel;
    logic [1:0]         csel;
    logic signed [31:0] coef;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        rad;
    bit                 drain;
  } cull_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = fsp_pkg::FUNC_LOAD;
  logic [2:0] in_plane_sel = '0;
  logic [1:0] in_coef_sel = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic [30:0] in_sphere_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_verdict;

  frustum_sphere_point_cull_core #(
    .PLANE_COUNT(PLANES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_plane_sel     (in_plane_sel),
    .in_coef_sel      (in_coef_sel),
    .in_coef_value    (in_coef_value),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_sphere_radius (in_sphere_radius),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict)
  );

  cull_item_t pend_q[$];
  logic [1:0] verdict_q[$];
  logic signed [31:0] plane_mem [PLANES*4];

  bit took = 1'b0;
  bit drain_next = 1'b0;
  int err_cnt = 0;
  int n_loads = 0;
  int n_spheres = 0;
  int n_points = 0;
  int n_inside = 0;
  int n_intersect = 0;
  int n_outside = 0;
  int push_cnt = 0;
  int unsigned cycles = 0;
  int unsigned box_w = 32'h0010_0000;
  int burst_left = 1;
  int gap_left = 0;
  int stall_len = 0;
  int stall_mode = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Distances are formed at 70 bits, wide enough for three full products plus d.
  function automatic logic [1:0] cull_verdict(cull_item_t it);
    logic signed [69:0] pos_r, neg_r, span;
    logic signed [69:0] ax, ay, az, ad, px, py, pz;
    bit hit_out, hit_near;
    hit_out = 1'b0;
    hit_near = 1'b0;
    pos_r = {23'd0, it.rad, 16'd0};
    neg_r = -pos_r;
    px = 70'(it.px);
    py = 70'(it.py);
    pz = 70'(it.pz);
    if (it.func != fsp_pkg::FUNC_SPHERE && it.func != fsp_pkg::FUNC_POINT)
      return fsp_pkg::VERDICT_INSIDE;
    for (int p = 0; p < PLANES; p++) begin
      ax = 70'(plane_mem[4*p]);
      ay = 70'(plane_mem[4*p+1]);
      az = 70'(plane_mem[4*p+2]);
      ad = 70'(plane_mem[4*p+3]);
      span = ax * px + ay * py + az * pz + (ad <<< 16);
      if (it.func == fsp_pkg::FUNC_SPHERE) begin
        if (span < neg_r) hit_out = 1'b1;
        else if (span < pos_r) hit_near = 1'b1;
      end else if (span < 0) begin
        hit_out = 1'b1;
      end
    end
    if (hit_out) return fsp_pkg::VERDICT_OUTSIDE;
    if (hit_near) return fsp_pkg::VERDICT_INTERSECT;
    return fsp_pkg::VERDICT_INSIDE;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: begin
        case ($urandom_range(0, 3))
          0: return MIN_WORD;
          1: return MAX_WORD;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] near_coord(int unsigned w);
    return $urandom_range(0, 3 * w) - (3 * w) / 2;
  endfunction

  // Radii stay below 2^31; push_test keeps the low 31 bits.
  function automatic logic [31:0] rand_radius(int unsigned w);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom & 32'h7fff_ffff;
      default: return $urandom_range(0, w);
    endcase
  endfunction

  task automatic push_load(int p, int c, logic [31:0] v);
    cull_item_t it;
    it.func = fsp_pkg::FUNC_LOAD;
    it.psel = 3'(p);
    it.csel = 2'(c);
    it.coef = v;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.rad = 31'($urandom);
    it.drain = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(it);
    push_cnt++;
  endtask

  task automatic push_test(logic [1:0] f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] r);
    cull_item_t it;
    it.func = f;
    it.psel = 3'($urandom);
    it.csel = 2'($urandom);
    it.coef = $urandom;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.rad = r[30:0];
    it.drain = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(it);
    push_cnt++;
  endtask

  // Axis-aligned box of half-width w: planes +x, -x, +y, -y, +z, -z.
  task automatic load_box(int unsigned w);
    for (int p = 0; p < PLANES; p++) begin
      for (int c = 0; c < 3; c++) begin
        if (c == p / 2) push_load(p, c, (p % 2) ? -ONE_Q16 : ONE_Q16);
        else push_load(p, c, 32'h0);
      end
      push_load(p, 3, w);
    end
  endtask

  task automatic build_directed();
    int unsigned w;
    int unsigned r;
    w = box_w;
    r = w / 4;
    load_box(w);
    push_test(fsp_pkg::FUNC_POINT, 0, 0, 0, 0);
    push_test(fsp_pkg::FUNC_POINT, -w, 0, 0, $urandom);
    push_test(fsp_pkg::FUNC_POINT, -w - 1, 0, 0, $urandom);
    push_test(fsp_pkg::FUNC_SPHERE, 0, 0, 0, w / 2);
    // Sphere touching the -x face from outside, then one step further out.
    push_test(fsp_pkg::FUNC_SPHERE, -w - r, 0, 0, r);
    push_test(fsp_pkg::FUNC_SPHERE, -w - r - 1, 0, 0, r);
    push_test(fsp_pkg::FUNC_SPHERE, -w + r, 0, 0, r);
    push_test(fsp_pkg::FUNC_SPHERE, 0, 0, 0, 32'h7fff_ffff);
    push_test(fsp_pkg::FUNC_SPHERE, -w, 0, 0, 0);
    push_test(fsp_pkg::FUNC_POINT, MAX_WORD, MAX_WORD, MAX_WORD, 0);
    // Loads to plane numbers past the last plane must leave the box intact.
    push_load(6, 0, MIN_WORD);
    push_load(7, 3, MAX_WORD);
    push_test(FUNC_UNUSED, MIN_WORD, MAX_WORD, MIN_WORD, 32'h7fff_ffff);
    push_test(fsp_pkg::FUNC_POINT, 0, 0, 0, 0);
    push_load(5, 0, MIN_WORD);
    push_load(5, 1, MIN_WORD);
    push_load(5, 2, MIN_WORD);
    push_load(5, 3, MAX_WORD);
    push_test(fsp_pkg::FUNC_POINT, MIN_WORD, MIN_WORD, MIN_WORD, 0);
    push_test(fsp_pkg::FUNC_POINT, MAX_WORD, MAX_WORD, MAX_WORD, 0);
    push_test(fsp_pkg::FUNC_SPHERE, MIN_WORD, MIN_WORD, MIN_WORD, 32'h7fff_ffff);
    push_test(fsp_pkg::FUNC_SPHERE, MAX_WORD, MAX_WORD, MAX_WORD, 32'h7fff_ffff);
  endtask

  task automatic build_random();
    int start;
    int n_tests;
    int pick;
    start = push_cnt;
    while (push_cnt - start < RANDOM_ITEMS) begin
      drain_next = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        box_w = $urandom_range(1, 32'h0040_0000);
        load_box(box_w);
      end else if (pick == 4) begin
        for (int i = 0; i < PLANES * 4; i++) push_load(i / 4, i % 4, rand_word());
      end else begin
        repeat ($urandom_range(1, 3))
          push_load($urandom_range(0, PLANES - 1), $urandom_range(0, 3), rand_word());
      end
      n_tests = $urandom_range(20, 60);
      repeat (n_tests) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          push_load($urandom_range(PLANES, 7), $urandom_range(0, 3), $urandom);
        end else if (pick == 1) begin
          push_test(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end else if ($urandom_range(0, 9) < 7) begin
          push_test((pick < 11) ? fsp_pkg::FUNC_SPHERE : fsp_pkg::FUNC_POINT,
                    near_coord(box_w), near_coord(box_w), near_coord(box_w),
                    rand_radius(box_w));
        end else begin
          push_test((pick < 11) ? fsp_pkg::FUNC_SPHERE : fsp_pkg::FUNC_POINT, rand_word(),
                    rand_word(), rand_word(), rand_radius(box_w));
        end
      end
    end
  endtask

  // Input side: the accepted item updates the plane copy and queues its verdict.
  always @(posedge clk) begin : accept_side
    cull_item_t it;
    bit taken;
    taken = rst_n && in_valid && !in_stall;
    if (taken) begin
      it.func = in_func;
      it.psel = in_plane_sel;
      it.csel = in_coef_sel;
      it.coef = in_coef_value;
      it.px = in_pos_x;
      it.py = in_pos_y;
      it.pz = in_pos_z;
      it.rad = in_sphere_radius;
      it.drain = 1'b0;
      verdict_q.push_back(cull_verdict(it));
      if (it.func == fsp_pkg::FUNC_LOAD) begin
        n_loads++;
        if (it.psel < PLANES) plane_mem[it.psel * 4 + it.csel] = it.coef;
      end else if (it.func == fsp_pkg::FUNC_SPHERE) begin
        n_spheres++;
      end else if (it.func == fsp_pkg::FUNC_POINT) begin
        n_points++;
      end
    end
    took <= taken;
  end

  // Driver: bursts of items with random gaps; an item marked drain waits for an empty pipe.
  always @(negedge clk) begin : drive_side
    cull_item_t nxt;
    bit send;
    send = 1'b0;
    if (rst_n && !(in_valid && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_q.size() > 0 && !(pend_q[0].drain && verdict_q.size() != 0)) begin
        nxt = pend_q.pop_front();
        send = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_valid <= send;
      if (send) begin
        in_func <= nxt.func;
        in_plane_sel <= nxt.psel;
        in_coef_sel <= nxt.csel;
        in_coef_value <= nxt.coef;
        in_pos_x <= nxt.px;
        in_pos_y <= nxt.py;
        in_pos_z <= nxt.pz;
        in_sphere_radius <= nxt.rad;
      end
    end
  end

  // Result side stall: modes of random length, from no stall to mostly stalled.
  always @(negedge clk) begin : stall_side
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_len = $urandom_range(20, 150);
    end
    stall_len--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycles[3];
    endcase
  end

  always @(posedge clk) begin : result_side
    logic [1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 20)
          $display("%0t: verdict %0d with no item outstanding", $time, out_verdict);
      end else begin
        want = verdict_q.pop_front();
        if (out_verdict !== want) begin
          err_cnt++;
          if (err_cnt <= 20)
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want,
                     out_verdict);
        end
        case (want)
          fsp_pkg::VERDICT_INSIDE: n_inside++;
          fsp_pkg::VERDICT_INTERSECT: n_intersect++;
          default: n_outside++;
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PLANES * 4; i++) plane_mem[i] = '0;
    build_directed();
    drain_next = 1'b1;
    build_random();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (pend_q.size() == 0 && !in_valid);
    wait (verdict_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) err_cnt++;
    $display("Checked %0d loads, %0d sphere tests and %0d point tests under random stalls.",
             n_loads, n_spheres, n_points);
    $display("Verdicts seen: %0d inside, %0d intersect, %0d outside.", n_inside,
             n_intersect, n_outside);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
